/* src/expr_tok_pkg.sv */
// ----------------------------------------------------------------------------
// expr_tok_pkg
// Types, token codes and character classes for the expression tokenizer.
// ----------------------------------------------------------------------------
package expr_tok_pkg;

   localparam int MAX_LEN_BITS = 16;
   localparam int POS_WIDTH    = 16;
   localparam logic [POS_WIDTH-1:0] POS_CAP =
      (MAX_LEN_BITS >= POS_WIDTH) ? {POS_WIDTH{1'b1}}
                                  : POS_WIDTH'((64'd1 << MAX_LEN_BITS) - 64'd1);

   // number flag bit positions
   localparam int FLAG_DIG   = 0;
   localparam int FLAG_DOT   = 1;
   localparam int FLAG_EXP   = 2;
   localparam int FLAG_JUSTE = 3;

   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_E_LOW  = 8'h65;
   localparam logic [7:0] CH_E_UP   = 8'h45;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_OPEN   = 8'h28;
   localparam logic [7:0] CH_CLOSE  = 8'h29;

   typedef enum logic [3:0] {
      KIND_EOF    = 4'd0,
      KIND_BAD    = 4'd1,
      KIND_NUM    = 4'd2,
      KIND_NAME   = 4'd3,
      KIND_SUB    = 4'd4,
      KIND_ADD    = 4'd5,
      KIND_MUL    = 4'd6,
      KIND_DIV    = 4'd7,
      KIND_MOD    = 4'd8,
      KIND_POW    = 4'd9,
      KIND_SEP    = 4'd10,
      KIND_LPAREN = 4'd11,
      KIND_RPAREN = 4'd12
   } tok_kind_type;

   typedef enum logic [1:0] {
      SCAN_IDLE  = 2'd0,
      SCAN_NUM   = 2'd1,
      SCAN_IDENT = 2'd2,
      SCAN_ERR   = 2'd3
   } scan_mode_type;

   typedef struct packed {
      tok_kind_type           kind;
      logic [POS_WIDTH-1:0]   offset;
      logic [POS_WIDTH-1:0]   length;
      logic                   last;
   } tok_res_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c inside {8'h20, [8'h09:8'h0D]};
   endfunction

   // KIND_EOF means "not a one-character token"
   function automatic tok_kind_type single_kind(input logic [7:0] c);
      tok_kind_type k;
      case (c)
         CH_MINUS: k = KIND_SUB;
         CH_PLUS:  k = KIND_ADD;
         CH_STAR:  k = KIND_MUL;
         CH_SLASH: k = KIND_DIV;
         CH_PCT:   k = KIND_MOD;
         CH_CARET: k = KIND_POW;
         CH_COMMA: k = KIND_SEP;
         CH_OPEN:  k = KIND_LPAREN;
         CH_CLOSE: k = KIND_RPAREN;
         default:  k = KIND_EOF;
      endcase
      return k;
   endfunction

endpackage

/* src/expression_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// expression_tokenizer_core
// Streaming lexer: one character per request, tokens out as they end.
// ----------------------------------------------------------------------------
//  channel | direction | ports                                    | per request
//  --------+-----------+------------------------------------------+-------------
//  req     | in        | req_valid/req_stall, ch, end_mark        | one character
//  rsp     | out       | rsp_valid/rsp_stall, kind, offset, length| 0..2 tokens
//
//  A character is decoded in the cycle it is taken; its tokens sit in a
//  two-entry result buffer the next cycle. A request is taken only when the
//  buffer drains in that cycle, so one request per cycle while rsp_stall is low
//  and each yields at most one token; two tokens stall req until both drain.
//  Reset (synchronous) clears scan state, position and the result buffer count.
//  req_stall follows rsp_stall combinationally through the buffer drain check.
module expression_tokenizer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_end_mark,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_token_kind,
   output logic [15:0] rsp_token_offset,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last
);
   import expr_tok_pkg::*;

   scan_mode_type          mode_ff, mode_in;
   logic [3:0]             flags_ff, flags_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [POS_WIDTH-1:0]   tstart_ff, tstart_in;

   tok_res_type            q0_ff, q0_in, q1_ff, q1_in;
   logic [1:0]             cnt_ff, cnt_in;

   logic                   pop, accept, drained;
   logic [1:0]             remain;

   // start-of-token decode
   tok_kind_type           st_single;
   logic                   st_emit, st_load;
   scan_mode_type          st_mode;
   logic [3:0]             st_flags;
   tok_res_type            st_res;

   // pending token and malformed-number token
   tok_res_type            fin_res, err_res, eof_res;
   logic                   fin_emit;
   logic [POS_WIDTH-1:0]   tok_len;

   // results of this request
   logic                   use_a, use_b;
   tok_res_type            res_a, res_b;
   logic [1:0]             nres;
   logic [7:0]             c;

   assign c = req_ch;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign remain    = cnt_ff - {1'b0, pop};
   assign drained   = (remain == 2'd0);
   assign req_stall = !drained;
   assign accept    = req_valid && drained;

   assign rsp_token_kind   = q0_ff.kind;
   assign rsp_token_offset = q0_ff.offset;
   assign rsp_token_length = q0_ff.length;
   assign rsp_last         = q0_ff.last;

   assign tok_len = pos_ff - tstart_ff;

   always_comb begin
      st_single = single_kind(c);
      st_emit   = 1'b0;
      st_load   = 1'b0;
      st_mode   = SCAN_IDLE;
      st_flags  = 4'd0;
      st_res    = '{kind: st_single, offset: pos_ff, length: POS_WIDTH'(1), last: 1'b0};
      if (is_blank(c)) begin
         st_mode = SCAN_IDLE;
      end else if (is_digit(c) || c == CH_DOT) begin
         st_mode  = SCAN_NUM;
         st_load  = 1'b1;
         st_flags = is_digit(c) ? (4'd1 << FLAG_DIG) : (4'd1 << FLAG_DOT);
      end else if (is_alpha(c) || c == CH_UNDER) begin
         st_mode = SCAN_IDENT;
         st_load = 1'b1;
      end else if (st_single != KIND_EOF) begin
         st_emit = 1'b1;
      end else begin
         st_mode = SCAN_ERR;
         st_emit = 1'b1;
         st_res  = '{kind: KIND_BAD, offset: pos_ff, length: '0, last: 1'b0};
      end
   end

   always_comb begin
      err_res  = '{kind: KIND_BAD, offset: tstart_ff, length: '0, last: 1'b0};
      eof_res  = '{kind: KIND_EOF, offset: '0, length: '0, last: 1'b0};
      fin_emit = (mode_ff == SCAN_NUM) || (mode_ff == SCAN_IDENT);
      fin_res  = '{kind: KIND_NAME, offset: tstart_ff, length: tok_len, last: 1'b0};
      if (mode_ff == SCAN_NUM) begin
         if (flags_ff[FLAG_DIG]) begin
            fin_res.kind = KIND_NUM;
         end else begin
            fin_res = err_res;
         end
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      flags_in  = flags_ff;
      tstart_in = tstart_ff;
      pos_in    = pos_ff;
      use_a     = 1'b0;
      use_b     = 1'b0;
      res_a     = fin_res;
      res_b     = st_res;
      if (req_end_mark) begin
         use_a     = fin_emit;
         use_b     = 1'b1;
         res_b     = eof_res;
         mode_in   = SCAN_IDLE;
         flags_in  = '0;
         tstart_in = '0;
         pos_in    = '0;
      end else begin
         if (pos_ff < POS_CAP) begin
            pos_in = pos_ff + POS_WIDTH'(1);
         end
         case (mode_ff)
            SCAN_IDLE: begin
               mode_in  = st_mode;
               flags_in = st_flags;
               use_b    = st_emit;
               if (st_load) tstart_in = pos_ff;
            end
            SCAN_IDENT: begin
               if (!(is_alpha(c) || is_digit(c) || c == CH_UNDER)) begin
                  use_a    = 1'b1;
                  mode_in  = st_mode;
                  flags_in = st_flags;
                  use_b    = st_emit;
                  if (st_load) tstart_in = pos_ff;
               end
            end
            SCAN_NUM: begin
               if (is_digit(c)) begin
                  flags_in = flags_ff | (4'd1 << FLAG_DIG);
                  flags_in[FLAG_JUSTE] = 1'b0;
               end else if (c == CH_DOT) begin
                  if (flags_ff[FLAG_DOT] || flags_ff[FLAG_EXP]) begin
                     mode_in = SCAN_ERR;
                     use_a   = 1'b1;
                     res_a   = err_res;
                  end else begin
                     flags_in = flags_ff | (4'd1 << FLAG_DOT);
                     flags_in[FLAG_JUSTE] = 1'b0;
                  end
               end else if (c == CH_E_LOW || c == CH_E_UP) begin
                  if (!flags_ff[FLAG_DIG] || flags_ff[FLAG_EXP]) begin
                     mode_in = SCAN_ERR;
                     use_a   = 1'b1;
                     res_a   = err_res;
                  end else begin
                     flags_in = flags_ff | (4'd1 << FLAG_EXP) | (4'd1 << FLAG_JUSTE);
                     flags_in[FLAG_DIG] = 1'b0;
                  end
               end else if ((c == CH_PLUS || c == CH_MINUS) && flags_ff[FLAG_JUSTE]) begin
                  flags_in[FLAG_JUSTE] = 1'b0;
               end else if (!flags_ff[FLAG_DIG]) begin
                  mode_in  = SCAN_ERR;
                  flags_in = '0;
                  use_a    = 1'b1;
                  res_a    = err_res;
               end else begin
                  use_a    = 1'b1;
                  mode_in  = st_mode;
                  flags_in = st_flags;
                  use_b    = st_emit;
                  if (st_load) tstart_in = pos_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // pack results and update the result buffer
   always_comb begin
      tok_res_type first_r, second_r;
      first_r  = use_a ? res_a : res_b;
      second_r = res_b;
      nres     = {1'b0, use_a} + {1'b0, use_b};
      first_r.last  = (nres == 2'd1);
      second_r.last = 1'b1;

      q0_in  = q0_ff;
      q1_in  = q1_ff;
      cnt_in = remain;
      if (pop && cnt_ff == 2'd2) begin
         q0_in = q1_ff;
      end
      if (accept) begin
         q0_in  = first_r;
         q1_in  = second_r;
         cnt_in = nres;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= SCAN_IDLE;
         flags_ff  <= '0;
         pos_ff    <= '0;
         tstart_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (accept) begin
            mode_ff   <= mode_in;
            flags_ff  <= flags_in;
            pos_ff    <= pos_in;
            tstart_ff <= tstart_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result buffer count out of range");

   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && !rsp_stall)))
      else $error("request taken without room for its tokens");

   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_token_kind == KIND_EOF) |-> (rsp_last && rsp_token_length == '0))
      else $error("eof token not last or nonzero length");

   a_invalid_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_token_kind == KIND_BAD) |-> rsp_token_length == '0)
      else $error("invalid token with nonzero length");

   a_end_restart: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_end_mark) |=> (pos_ff == '0 && mode_ff == SCAN_IDLE))
      else $error("end marker did not restart the scan");

endmodule
